// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Active in simulation, empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/topk_pkg.sv
// Package for the top-k selector: widths, register indexes, key function.
// No dependencies.
package topk_pkg;
  localparam int MaxKeepDefault = 16;
  localparam int MaxRowLenDefault = 65536;
  localparam int ValW = 32;
  localparam int PosW = 16;
  localparam int CntW = 5;
  localparam int CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] RegKeepCount = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPickLargest = 8'd1;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [PosW-1:0] pos;
    logic            vld;
  } entry_t;

  // Signals from the chain to one cell about the incoming word.
  typedef struct packed {
    logic            go;
    logic            flush;
    logic            pick_largest;
    logic [ValW-1:0] value;
    logic [PosW-1:0] pos;
  } cell_ctl_t;

  function automatic logic [ValW-1:0] order_key(input logic [ValW-1:0] bits);
    logic [ValW-1:0] b;
    b = (bits == 32'h8000_0000) ? '0 : bits;
    return b[ValW-1] ? ~b : (b | 32'h8000_0000);
  endfunction
endpackage

// File: hw/rtl/topk_cell.sv
// One slot of the sorted chain: holds an entry, takes the new word or the
// left neighbor's entry. Depends on topk_pkg.
module topk_cell (
  input  logic              clk,
  input  logic              rst,
  input  topk_pkg::cell_ctl_t ctl,
  input  logic              enable,   // slot index below the keep limit
  input  logic              left_beat, // new word beats left neighbor
  input  logic              left_is_first,
  input  topk_pkg::entry_t  left,
  output logic              beat,
  output topk_pkg::entry_t  slot
);
  import topk_pkg::*;
  logic [ValW-1:0] ka, kb;
  logic here_ins;
  entry_t slot_next;

  assign ka = order_key(ctl.value);
  assign kb = order_key(slot.value);
  // empty slot is always beaten
  assign beat = !slot.vld || (ctl.pick_largest ? (ka > kb) : (ka < kb));
  assign here_ins = beat && (left_is_first || !left_beat);

  always_comb begin
    slot_next = slot;
    if (!enable) begin
      slot_next.vld = 1'b0;
    end else if (here_ins) begin
      slot_next.value = ctl.value;
      slot_next.pos = ctl.pos;
      slot_next.vld = 1'b1;
    end else if (beat && !left_is_first) begin
      slot_next = left;
    end
    if (ctl.flush) slot_next.vld = 1'b0;
  end

  // a slot past the limit drops only when the next word arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.vld <= 1'b0;
    end else if (ctl.go) begin
      slot.vld <= slot_next.vld;
    end
    if (ctl.go) begin
      slot.value <= slot_next.value;
      slot.pos <= slot_next.pos;
    end
  end
endmodule

// File: hw/rtl/topk_drain.sv
// Output side: holds a snapshot of a finished row and streams it best first.
// Depends on topk_pkg.
module topk_drain #(
  parameter int MAX_KEEP = topk_pkg::MaxKeepDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  topk_pkg::entry_t        snap [MAX_KEEP],
  input  logic [$clog2(MAX_KEEP+1)-1:0] snap_cnt,
  input  logic                    snap_short,
  output logic                    busy,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output topk_pkg::entry_t        head,
  output logic                    last,
  output logic                    short_row
);
  import topk_pkg::*;
  localparam int NW = $clog2(MAX_KEEP+1);
  entry_t q [MAX_KEEP];
  logic [NW-1:0] left;
  logic take;

  assign take = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (left != '0);
  assign busy = (left > NW'(1)) || (left == NW'(1) && !take);
  assign head = q[0];
  assign last = (left == NW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= snap_cnt;
    end else if (take) begin
      left <= left - NW'(1);
    end
    if (load) begin
      short_row <= snap_short;
      for (int i = 0; i < MAX_KEEP; i++) q[i] <= snap[i];
    end else if (take) begin
      // advance the queue one slot
      for (int i = 0; i < MAX_KEEP - 1; i++) q[i] <= q[i+1];
    end
  end
endmodule

// File: hw/rtl/topk_select_with_index.sv
// Top-k selector with positions: chain of compare-and-shift cells plus drain.
// Accepts one word per cycle, but stalls a row end word while the drain is
// busy. Results follow a row end from the next cycle on, one per cycle while
// m_axis_tready is high; other words of the next row are taken meanwhile.
// Synchronous active-high reset empties chain, drain and position counter.
`include "assert_macros.svh"
module topk_select_with_index #(
  parameter int MAX_KEEP = topk_pkg::MaxKeepDefault,
  parameter longint MAX_ROW_LEN = topk_pkg::MaxRowLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value_bits
  input  logic        s_axis_tlast,  // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // best_position, best_value_bits
  output logic        m_axis_tlast,  // final_of_row
  output logic        m_axis_tuser,  // row_too_short
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [topk_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import topk_pkg::*;
  localparam int NW = $clog2(MAX_KEEP+1);

  logic [CntW-1:0] keep_count;
  logic pick_largest;
  logic [PosW-1:0] pos;
  logic [NW-1:0] lim, cnt, cnt_new;
  logic go, busy;
  cell_ctl_t ctl;
  entry_t slots [MAX_KEEP];
  entry_t snap [MAX_KEEP];
  logic [MAX_KEEP-1:0] beats;
  entry_t head;
  logic dlast, dshort;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= CntW'(1);
      pick_largest <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == RegKeepCount) keep_count <= cfg_data[CntW-1:0];
      if (cfg_index == RegPickLargest) pick_largest <= cfg_data[0];
    end
  end

  always_comb begin
    if (keep_count == '0) lim = NW'(1);
    else if (32'(keep_count) > MAX_KEEP) lim = NW'(MAX_KEEP);
    else lim = NW'(keep_count);
  end

  assign s_axis_tready = !(s_axis_tlast && busy);
  assign go = s_axis_tvalid && s_axis_tready;
  assign ctl.go = go;
  assign ctl.flush = s_axis_tlast;
  assign ctl.pick_largest = pick_largest;
  assign ctl.value = s_axis_tdata;
  assign ctl.pos = pos;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    topk_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .enable(32'(i) < 32'(lim)),
      .left_beat(i == 0 ? 1'b0 : beats[(i == 0) ? 0 : i-1]),
      .left_is_first(i == 0),
      .left(slots[(i == 0) ? 0 : i-1]),
      .beat(beats[i]),
      .slot(slots[i])
    );
    // row end view: the cells' next contents without the flush
    always_comb begin
      snap[i] = slots[i];
      if (32'(i) >= 32'(lim)) snap[i].vld = 1'b0;
      else if (beats[i] && (i == 0 || !beats[(i == 0) ? 0 : i-1])) begin
        snap[i].value = s_axis_tdata;
        snap[i].pos = pos;
        snap[i].vld = 1'b1;
      end else if (beats[i] && i != 0) begin
        snap[i] = slots[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < MAX_KEEP; i++)
      if (slots[i].vld && 32'(i) < 32'(lim)) cnt = NW'(i + 1);
    cnt_new = (cnt < lim) ? cnt + NW'(1) : cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (go) begin
      if (s_axis_tlast || 64'(pos) + 64'd1 >= 64'(MAX_ROW_LEN)) pos <= '0;
      else pos <= pos + PosW'(1);
    end
  end

  topk_drain #(.MAX_KEEP(MAX_KEEP)) u_drain (
    .clk(clk), .rst(rst), .load(go && s_axis_tlast),
    .snap(snap), .snap_cnt(cnt_new), .snap_short(cnt_new < lim),
    .busy(busy), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .head(head), .last(dlast), .short_row(dshort)
  );

  assign m_axis_tdata = {head.pos, head.value};
  assign m_axis_tlast = dlast;
  assign m_axis_tuser = dshort;

  `ASSERT_CLK(a_no_row_end_while_busy, clk, rst,
    (go && s_axis_tlast) |-> !busy, "row end taken while drain busy")
  `ASSERT_CLK(a_pos_clear_after_row, clk, rst,
    (go && s_axis_tlast) |=> (pos == '0), "position not cleared at row end")
  `ASSERT_CLK(a_out_after_row_end, clk, rst,
    (go && s_axis_tlast) |=> m_axis_tvalid, "no results after row end")
endmodule
